>>> sv/stdp_pkg.sv
package stdp_pkg;

  // parser phases
  typedef enum logic [2:0] {
    PH_HUNT,
    PH_TYPE,
    PH_NAME,
    PH_SCAN,
    PH_SKIP
  } phase_e;

  // result kinds
  localparam logic [1:0] KIND_DIST = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_CMD     = 2'd1;
  localparam logic [1:0] ERR_SECTION = 2'd2;
  localparam logic [1:0] ERR_ETX     = 2'd3;

  // framing bytes
  localparam logic [7:0] BYTE_STX = 8'h02;
  localparam logic [7:0] BYTE_ETX = 8'h03;
  localparam logic [7:0] BYTE_SP  = 8'h20;

  // command types
  localparam logic [23:0] TYPE_SSN = 24'h73534E;
  localparam logic [23:0] TYPE_SEA = 24'h734541;
  localparam logic [23:0] TYPE_SAN = 24'h73414E;
  localparam logic [23:0] TYPE_SRA = 24'h735241;
  localparam logic [23:0] TYPE_SWA = 24'h735741;

  localparam logic [3:0] TYPE_LEN      = 4'd3;
  localparam logic [3:0] SCAN_NAME_LEN = 4'd11;
  localparam logic [3:0] NAME_POS_MAX  = 4'd15;
  localparam logic [2:0] DIST_NAME_LEN = 3'd5;
  localparam logic [2:0] HEX_DIGITS    = 3'd4;
  localparam logic [2:0] TOK_LEN_MAX   = 3'd7;

  // token positions inside the scan telegram
  localparam logic [5:0] TOK_ENC_COUNT  = 6'd16;
  localparam logic [5:0] TOK_ENC_FIRST  = 6'd17;
  localparam logic [5:0] TOK_AFTER_ENC  = 6'd19;
  localparam logic [5:0] TOK_CHAN_NAME  = 6'd20;
  localparam logic [5:0] TOK_DATA_COUNT = 6'd25;
  localparam logic [5:0] TOK_DATA       = 6'd26;
  localparam logic [5:0] TOK_CH8_COUNT  = 6'd27;
  localparam logic [5:0] TOK_NAME_FLAG  = 6'd29;
  localparam logic [5:0] TOK_TIME_FLAG  = 6'd31;
  localparam logic [5:0] TOK_EVENT_FLAG = 6'd32;

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
    else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
    return v;
  endfunction

  function automatic logic known_type(input logic [23:0] t);
    return (t == TYPE_SSN) || (t == TYPE_SEA) || (t == TYPE_SAN) ||
           (t == TYPE_SRA) || (t == TYPE_SWA);
  endfunction

  // "LMDscandata"
  function automatic logic [7:0] scan_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'h4C;
      4'd1:    c = 8'h4D;
      4'd2:    c = 8'h44;
      4'd3:    c = 8'h73;
      4'd4:    c = 8'h63;
      4'd5:    c = 8'h61;
      4'd6:    c = 8'h6E;
      4'd7:    c = 8'h64;
      4'd8:    c = 8'h61;
      4'd9:    c = 8'h74;
      4'd10:   c = 8'h61;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "DIST1"
  function automatic logic [7:0] dist_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h44;
      3'd1:    c = 8'h49;
      3'd2:    c = 8'h53;
      3'd3:    c = 8'h54;
      3'd4:    c = 8'h31;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> sv/scan_telegram_distance_parser_unit.sv
// path: an accepted byte is held in the input register and its result is registered in the output register
// throughput: one byte per cycle while the result side is not stalled
// a stalled result beat holds the next byte in the input register
// reset: rst_ni is asynchronous and active low; it empties both stages and
// puts the parser in the hunt-for-stx phase with all counters cleared
module scan_telegram_distance_parser_unit
  import stdp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic [15:0] distance_o,
  output logic [15:0] point_index_o,
  output logic        last_point_o,
  output logic [1:0]  error_code_o
);

  // input stage
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       advance;
  logic       in_take;

  // parser state
  phase_e      phase_q, phase_d;
  logic [23:0] cmd_q, cmd_d;
  logic [3:0]  name_pos_q, name_pos_d;
  logic        name_scan_q, name_scan_d;
  logic [5:0]  tok_num_q, tok_num_d;
  logic [15:0] hex_acc_q, hex_acc_d;
  logic [2:0]  tok_len_q, tok_len_d;
  logic        chan_dist_q, chan_dist_d;
  logic [15:0] pts_total_q, pts_total_d;
  logic [15:0] pts_done_q, pts_done_d;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [1:0]  kind_q;
  logic [15:0] dist_q;
  logic [15:0] idx_q;
  logic        last_q;
  logic [1:0]  err_q;

  // decode of the current byte
  logic        is_etx, is_delim;
  logic [23:0] type_word;
  logic        is_scan;
  logic [15:0] pd_inc;
  logic        pd_last;

  // outcome of closing a scan token
  logic        et_fail;
  logic [1:0]  et_err;
  logic        et_complete;
  logic        et_emit;
  logic [5:0]  et_next;

  // result of this byte
  logic        res_valid;
  logic [1:0]  res_kind;
  logic [15:0] res_dist;
  logic [15:0] res_idx;
  logic        res_last;
  logic [1:0]  res_err;

  // the stage moves whenever the output register is free or being drained
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  assign is_etx    = (in_byte_q == BYTE_ETX);
  assign is_delim  = is_etx || (in_byte_q == BYTE_SP);
  assign type_word = {cmd_q[15:0], in_byte_q};
  assign is_scan   = name_scan_q && (name_pos_q == SCAN_NAME_LEN) && (cmd_q == TYPE_SSN);
  assign pd_inc    = pts_done_q + 16'd1;
  assign pd_last   = (pd_inc == pts_total_q);

  // what ending the current token does
  always_comb begin
    et_fail     = 1'b0;
    et_err      = ERR_NONE;
    et_complete = 1'b0;
    et_emit     = 1'b0;
    et_next     = tok_num_q + 6'd1;
    if (is_etx && tok_num_q != TOK_EVENT_FLAG) begin
      // etx in the middle of the scan body wins over everything else
      et_fail = 1'b1;
      et_err  = ERR_ETX;
    end else begin
      case (tok_num_q)
        TOK_ENC_COUNT: begin
          // no encoder: jump over the two encoder tokens
          et_next = (hex_acc_q != 16'd0) ? TOK_ENC_FIRST : TOK_AFTER_ENC;
        end
        TOK_DATA_COUNT: begin
          et_next = (hex_acc_q != 16'd0) ? TOK_DATA : TOK_CH8_COUNT;
        end
        TOK_DATA: begin
          et_emit = chan_dist_q;
          et_next = pd_last ? TOK_CH8_COUNT : TOK_DATA;
        end
        TOK_CH8_COUNT: begin
          if (hex_acc_q != 16'd0) begin
            et_fail = 1'b1;
            et_err  = ERR_SECTION;
          end
        end
        TOK_NAME_FLAG: begin
          if (hex_acc_q == 16'd1) begin
            et_fail = 1'b1;
            et_err  = ERR_SECTION;
          end
        end
        TOK_TIME_FLAG: begin
          if (hex_acc_q != 16'd0) begin
            et_fail = 1'b1;
            et_err  = ERR_SECTION;
          end
        end
        TOK_EVENT_FLAG: begin
          if (hex_acc_q != 16'd0) begin
            et_fail = 1'b1;
            et_err  = ERR_SECTION;
          end else if (!is_etx) begin
            // trailer closed by a space instead of etx
            et_fail = 1'b1;
            et_err  = ERR_ETX;
          end else begin
            et_complete = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // next state of the parser
  always_comb begin
    phase_d     = phase_q;
    cmd_d       = cmd_q;
    name_pos_d  = name_pos_q;
    name_scan_d = name_scan_q;
    tok_num_d   = tok_num_q;
    hex_acc_d   = hex_acc_q;
    tok_len_d   = tok_len_q;
    chan_dist_d = chan_dist_q;
    pts_total_d = pts_total_q;
    pts_done_d  = pts_done_q;
    unique case (phase_q)
      PH_HUNT: begin
        if (in_byte_q == BYTE_STX) begin
          phase_d    = PH_TYPE;
          name_pos_d = 4'd0;
          cmd_d      = 24'd0;
        end
      end
      PH_TYPE: begin
        if (name_pos_q < TYPE_LEN) begin
          cmd_d      = type_word;
          name_pos_d = name_pos_q + 4'd1;
          if (name_pos_q == TYPE_LEN - 4'd1 && !known_type(type_word)) phase_d = PH_HUNT;
        end else if (is_etx) begin
          phase_d = PH_HUNT;
        end else begin
          // separator byte after the type
          phase_d     = PH_NAME;
          name_pos_d  = 4'd0;
          name_scan_d = 1'b1;
        end
      end
      PH_NAME: begin
        if (is_delim) begin
          if (is_etx) begin
            phase_d = PH_HUNT;
          end else if (is_scan) begin
            phase_d     = PH_SCAN;
            tok_num_d   = 6'd0;
            hex_acc_d   = 16'd0;
            tok_len_d   = 3'd0;
            chan_dist_d = 1'b1;
            pts_total_d = 16'd0;
            pts_done_d  = 16'd0;
          end else begin
            phase_d = PH_SKIP;
          end
        end else begin
          if (name_pos_q >= SCAN_NAME_LEN || in_byte_q != scan_char(name_pos_q)) begin
            name_scan_d = 1'b0;
          end
          if (name_pos_q < NAME_POS_MAX) name_pos_d = name_pos_q + 4'd1;
        end
      end
      PH_SCAN: begin
        if (is_delim) begin
          hex_acc_d = 16'd0;
          tok_len_d = 3'd0;
          if (et_fail || et_complete) begin
            phase_d = PH_HUNT;
          end else begin
            tok_num_d = et_next;
            if (tok_num_q == TOK_CHAN_NAME && tok_len_q != DIST_NAME_LEN) chan_dist_d = 1'b0;
            if (tok_num_q == TOK_DATA_COUNT) begin
              pts_total_d = hex_acc_q;
              pts_done_d  = 16'd0;
            end
            if (tok_num_q == TOK_DATA) pts_done_d = pd_inc;
          end
        end else begin
          if (tok_num_q == TOK_CHAN_NAME &&
              (tok_len_q >= DIST_NAME_LEN || in_byte_q != dist_char(tok_len_q))) begin
            chan_dist_d = 1'b0;
          end
          // only the first four characters form the value
          if (tok_len_q < HEX_DIGITS) hex_acc_d = {hex_acc_q[11:0], hex_nibble(in_byte_q)};
          if (tok_len_q < TOK_LEN_MAX) tok_len_d = tok_len_q + 3'd1;
        end
      end
      PH_SKIP: begin
        if (is_etx) phase_d = PH_HUNT;
      end
      default: begin
        phase_d = PH_HUNT;
      end
    endcase
  end

  // result of the current byte
  always_comb begin
    res_valid = 1'b0;
    res_kind  = KIND_DONE;
    res_dist  = 16'd0;
    res_idx   = 16'd0;
    res_last  = 1'b0;
    res_err   = ERR_NONE;
    unique case (phase_q)
      PH_TYPE: begin
        if (name_pos_q < TYPE_LEN) begin
          if (name_pos_q == TYPE_LEN - 4'd1 && !known_type(type_word)) begin
            res_valid = 1'b1;
            res_kind  = KIND_ERR;
            res_err   = ERR_CMD;
          end
        end else if (is_etx) begin
          res_valid = 1'b1;
        end
      end
      PH_NAME: begin
        if (is_etx) begin
          res_valid = 1'b1;
          if (is_scan) begin
            // scan telegram cut short after its name
            res_kind = KIND_ERR;
            res_err  = ERR_ETX;
          end
        end
      end
      PH_SCAN: begin
        if (is_delim) begin
          if (et_fail) begin
            res_valid = 1'b1;
            res_kind  = KIND_ERR;
            res_err   = et_err;
          end else if (et_complete) begin
            res_valid = 1'b1;
          end else if (et_emit) begin
            res_valid = 1'b1;
            res_kind  = KIND_DIST;
            res_dist  = hex_acc_q;
            res_idx   = pts_done_q;
            res_last  = pd_last;
          end
        end
      end
      PH_SKIP: begin
        if (is_etx) res_valid = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) in_valid_d = 1'b1;
    else if (advance) in_valid_d = 1'b0;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_valid_q && advance && res_valid) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_HUNT;
      cmd_q       <= 24'd0;
      name_pos_q  <= 4'd0;
      name_scan_q <= 1'b1;
      tok_num_q   <= 6'd0;
      hex_acc_q   <= 16'd0;
      tok_len_q   <= 3'd0;
      chan_dist_q <= 1'b1;
      pts_total_q <= 16'd0;
      pts_done_q  <= 16'd0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (in_valid_q && advance) begin
        phase_q     <= phase_d;
        cmd_q       <= cmd_d;
        name_pos_q  <= name_pos_d;
        name_scan_q <= name_scan_d;
        tok_num_q   <= tok_num_d;
        hex_acc_q   <= hex_acc_d;
        tok_len_q   <= tok_len_d;
        chan_dist_q <= chan_dist_d;
        pts_total_q <= pts_total_d;
        pts_done_q  <= pts_done_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) in_byte_q <= rx_byte_i;
    if (in_valid_q && advance && res_valid) begin
      kind_q <= res_kind;
      dist_q <= res_dist;
      idx_q  <= res_idx;
      last_q <= res_last;
      err_q  <= res_err;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign distance_o    = dist_q;
  assign point_index_o = idx_q;
  assign last_point_o  = last_q;
  assign error_code_o  = err_q;

endmodule

>>> sv/stdp_checker.sv
module stdp_checker
  import stdp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  result_kind_o,
  input logic [15:0] distance_o,
  input logic [15:0] point_index_o,
  input logic        last_point_o,
  input logic [1:0]  error_code_o
);

  // a stalled result beat stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(result_kind_o) && $stable(distance_o) &&
      $stable(point_index_o) && $stable(last_point_o) && $stable(error_code_o))
    else $error("result payload changed while stalled");

  // error code carried only by error beats
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((result_kind_o == KIND_ERR) == (error_code_o != ERR_NONE)) &&
      (result_kind_o == KIND_DIST || result_kind_o == KIND_DONE ||
       result_kind_o == KIND_ERR))
    else $error("error code does not match result kind");

  // distance fields are zero outside distance beats
  a_dist_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o != KIND_DIST) |->
      (distance_o == 16'd0) && (point_index_o == 16'd0) && !last_point_o)
    else $error("distance fields set on a non-distance beat");

  // input only stalls while the result side is stalled
  a_in_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while the receiver is ready");

endmodule

bind scan_telegram_distance_parser_unit stdp_checker u_stdp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .result_kind_o(result_kind_o),
  .distance_o   (distance_o),
  .point_index_o(point_index_o),
  .last_point_o (last_point_o),
  .error_code_o (error_code_o)
);
